### sv/http_chunked_body_decoder_assert.svh
// Assertion macros used by the chunked body decoder top level.
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CHD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chunked decoder check failed");

// Next-cycle implication, checked outside reset.
`define CHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chunked decoder check failed");

`endif

### sv/chd_pkg.sv
// Types, constants and the byte classifier of the chunked body decoder.
package chd_pkg;

    // Default length limit of one line, counted in bytes.
    localparam int LINE_BUFFER_DEF = 64;

    // Width of the chunk size counter.
    localparam int CNT_W = 64;

    // Characters the line parser looks for.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // Result codes.
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_LONG     = 2'd2;
    localparam logic [1:0] KIND_NO_CRLF  = 2'd3;

    // Decoder phases.
    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_DATA    = 3'd1,
        PH_CR      = 3'd2,
        PH_LF      = 3'd3,
        PH_TRAILER = 3'd4,
        PH_DONE    = 3'd5,
        PH_FAILED  = 3'd6
    } phase_t;

    // One input word.
    typedef struct packed {
        logic       start_of_body;
        logic [7:0] in_byte;
    } item_t;

    // One result word.
    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] out_byte;
    } result_t;

    // An input word with its byte already classified.
    typedef struct packed {
        logic       start_of_body;
        logic [7:0] in_byte;
        logic [3:0] hex_digit;
        logic       is_hex;
        logic       is_cr;
        logic       is_lf;
        logic       is_blank;
    } class_t;

    // Link from the front queue to the back end.
    typedef struct packed {
        logic   valid;
        class_t word;
    } link_t;

    // Decode a byte into its hex value and character class.
    function automatic class_t classify(item_t it);
        class_t     c;
        logic [7:0] b;
        b = it.in_byte;
        c.start_of_body = it.start_of_body;
        c.in_byte       = b;
        c.hex_digit     = 4'd0;
        c.is_hex        = 1'b0;
        if (b >= 8'h30 && b <= 8'h39) begin
            c.hex_digit = 4'(b - 8'h30);
            c.is_hex    = 1'b1;
        end else if (b >= 8'h61 && b <= 8'h66) begin
            c.hex_digit = 4'(b - 8'h57);
            c.is_hex    = 1'b1;
        end else if (b >= 8'h41 && b <= 8'h46) begin
            c.hex_digit = 4'(b - 8'h37);
            c.is_hex    = 1'b1;
        end
        c.is_cr    = (b == CH_CR);
        c.is_lf    = (b == CH_LF);
        c.is_blank = (b == CH_SPACE) || (b == CH_TAB);
        return c;
    endfunction

endpackage

### sv/chd_front.sv
// Front end: accepts input words, classifies the byte and queues the result.
module chd_front import chd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    output logic   full,
    input  item_t  item,
    output link_t  link,
    input  logic   take
);

    class_t     mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       accept;
    logic       drain;

    // Queue status toward both sides.
    assign full       = (count_reg == 2'd2);
    assign accept     = push && !full;
    assign link.valid = (count_reg != 2'd0);
    assign link.word  = mem_reg[rd_ptr_reg];
    assign drain      = take && link.valid;

    // Pointer and fill level updates.
    always_comb
    begin
        wr_ptr_next = accept ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = drain ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (accept && !drain)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!accept && drain)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Classified word storage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_reg[wr_ptr_reg] <= classify(item);
        end
    end

endmodule

### sv/chd_back.sv
// Back end: runs the chunk framing state machine and queues the results.
module chd_back import chd_pkg::*;
#(
    parameter int LINE_BUFFER = LINE_BUFFER_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  link_t   link,
    output logic    take,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    localparam int LEN_W = $clog2(LINE_BUFFER);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_BUFFER - 1);

    // Parser state.
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             cr_reg, cr_next;
    logic             de_reg, de_next;
    logic             plb_reg, plb_next;

    // Result queue.
    result_t    mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    class_t           w;
    phase_t           phase_eff;
    logic [CNT_W-1:0] cnt_eff;
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] len_inc;
    logic             cr_eff, de_eff, plb_eff;
    logic             line_end;
    logic             line_long;
    logic             emit;
    result_t          emit_word;
    logic             drain;

    assign w    = link.word;
    assign take = link.valid && (count_reg != 2'd2);

    // A start flag restarts the parser before the byte is used.
    always_comb
    begin
        if (w.start_of_body)
        begin
            phase_eff = PH_SIZE;
            cnt_eff   = '0;
            len_eff   = '0;
            cr_eff    = 1'b0;
            de_eff    = 1'b0;
            plb_eff   = 1'b0;
        end
        else
        begin
            phase_eff = phase_reg;
            cnt_eff   = cnt_reg;
            len_eff   = len_reg;
            cr_eff    = cr_reg;
            de_eff    = de_reg;
            plb_eff   = plb_reg;
        end
        len_inc   = len_eff + LEN_W'(1);
        line_end  = cr_eff && w.is_lf;
        line_long = !line_end && (len_inc >= LEN_LIMIT);
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            phase_next = phase_eff;
            unique case (phase_eff)
                PH_SIZE:
                begin
                    if (line_end)
                    begin
                        phase_next = (cnt_eff == '0) ? PH_TRAILER : PH_DATA;
                    end
                    else if (line_long)
                    begin
                        phase_next = PH_FAILED;
                    end
                end
                PH_DATA:
                begin
                    if (cnt_eff <= CNT_W'(1))
                    begin
                        phase_next = PH_CR;
                    end
                end
                PH_CR:
                begin
                    phase_next = w.is_cr ? PH_LF : PH_FAILED;
                end
                PH_LF:
                begin
                    phase_next = w.is_lf ? PH_SIZE : PH_FAILED;
                end
                PH_TRAILER:
                begin
                    if (line_long || (line_end && len_eff == LEN_W'(1)))
                    begin
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = phase_eff;
                end
            endcase
        end
    end

    // Results and line datapath.
    always_comb
    begin
        cnt_next  = cnt_reg;
        len_next  = len_reg;
        cr_next   = cr_reg;
        de_next   = de_reg;
        plb_next  = plb_reg;
        emit      = 1'b0;
        emit_word = '{result_kind: KIND_PAYLOAD, out_byte: 8'd0};
        if (take)
        begin
            cnt_next = cnt_eff;
            len_next = len_eff;
            cr_next  = cr_eff;
            de_next  = de_eff;
            plb_next = plb_eff;
            unique case (phase_eff)
                PH_SIZE:
                begin
                    if (line_end)
                    begin
                        len_next = '0;
                        cr_next  = 1'b0;
                        de_next  = 1'b0;
                        plb_next = 1'b0;
                    end
                    else
                    begin
                        cr_next  = w.is_cr;
                        len_next = len_inc;
                        if (plb_eff || !w.is_blank)
                        begin
                            plb_next = 1'b1;
                            if (!de_eff)
                            begin
                                if (!w.is_hex)
                                begin
                                    de_next = 1'b1;
                                end
                                else if (cnt_eff[CNT_W-1 -: 4] != 4'd0)
                                begin
                                    // Saturate once another digit would overflow.
                                    cnt_next = '1;
                                end
                                else
                                begin
                                    cnt_next = {cnt_eff[CNT_W-5:0], w.hex_digit};
                                end
                            end
                        end
                        if (line_long)
                        begin
                            emit      = 1'b1;
                            emit_word = '{result_kind: KIND_LONG, out_byte: 8'd0};
                        end
                    end
                end
                PH_DATA:
                begin
                    if (cnt_eff != '0)
                    begin
                        cnt_next = cnt_eff - CNT_W'(1);
                    end
                    emit      = 1'b1;
                    emit_word = '{result_kind: KIND_PAYLOAD, out_byte: w.in_byte};
                end
                PH_CR:
                begin
                    if (!w.is_cr)
                    begin
                        emit      = 1'b1;
                        emit_word = '{result_kind: KIND_NO_CRLF, out_byte: 8'd0};
                    end
                end
                PH_LF:
                begin
                    if (!w.is_lf)
                    begin
                        emit      = 1'b1;
                        emit_word = '{result_kind: KIND_NO_CRLF, out_byte: 8'd0};
                    end
                    else
                    begin
                        cnt_next = '0;
                        len_next = '0;
                        cr_next  = 1'b0;
                        de_next  = 1'b0;
                        plb_next = 1'b0;
                    end
                end
                PH_TRAILER:
                begin
                    if (line_long || (line_end && len_eff == LEN_W'(1)))
                    begin
                        emit      = 1'b1;
                        emit_word = '{result_kind: KIND_COMPLETE, out_byte: 8'd0};
                    end
                    else if (line_end)
                    begin
                        len_next = '0;
                        cr_next  = 1'b0;
                        de_next  = 1'b0;
                        plb_next = 1'b0;
                    end
                    else
                    begin
                        cr_next  = w.is_cr;
                        len_next = len_inc;
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    // Result queue control.
    assign empty  = (count_reg == 2'd0);
    assign result = mem_reg[rd_ptr_reg];
    assign drain  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = emit ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = drain ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (emit && !drain)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!emit && drain)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIZE;
            cnt_reg    <= '0;
            len_reg    <= '0;
            cr_reg     <= 1'b0;
            de_reg     <= 1'b0;
            plb_reg    <= 1'b0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            len_reg    <= len_next;
            cr_reg     <= cr_next;
            de_reg     <= de_next;
            plb_reg    <= plb_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result word storage.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            mem_reg[wr_ptr_reg] <= emit_word;
        end
    end

endmodule

### sv/http_chunked_body_decoder.sv
// Top level of the HTTP chunked body decoder.
//
// Channel   Handshake        Word
// input     push / full      item   : start_of_body, in_byte
// result    pop / empty      result : result_kind, out_byte
//
// One byte is taken per clock cycle while full is low; the parser state
// machine retires one word per cycle while the result queue has room. An
// accepted byte is registered in the classifier queue; once the parser takes
// it, its result is written to the result queue, from which it can be popped.
// Both queues hold two words; a stalled reader first fills the result queue,
// then the input queue, and only then raises full.
// Reset (rst_n low) empties both queues and puts the parser at a fresh size line.
`include "http_chunked_body_decoder_assert.svh"

module http_chunked_body_decoder import chd_pkg::*;
#(
    parameter int LINE_BUFFER = LINE_BUFFER_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  item_t   item,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    link_t link;
    logic  take;

    // Byte classifier and input queue.
    chd_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .link  (link),
        .take  (take)
    );

    // Framing state machine and result queue.
    chd_back #(
        .LINE_BUFFER (LINE_BUFFER)
    ) u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .link   (link),
        .take   (take),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // A full input queue always offers a word to the back end.
    `CHD_ASSERT_NOW(a_full_has_word, clk, rst_n, full, link.valid)
    // Only a payload result carries a nonzero byte.
    `CHD_ASSERT_NOW(a_status_byte_zero, clk, rst_n,
                    !empty && result.result_kind != KIND_PAYLOAD, result.out_byte == 8'd0)
    // A waiting result that is not popped is still there in the next cycle.
    `CHD_ASSERT_NEXT(a_result_kept, clk, rst_n, !empty && !pop, !empty)

endmodule

### sim/testbench.sv
// Self-checking testbench for the HTTP chunked body decoder.
`timescale 1ns / 100ps

module testbench;
    import chd_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          RANDOM_TARGET = 830;
    localparam int          DRAIN_CYCLES = 20;
    localparam logic [6:0]  LINE_LIMIT = 7'(LINE_BUFFER_DEF - 1);
    localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [7:0]  CH_SEMI = 8'h3B;
    localparam logic [7:0]  CH_DIGIT0 = 8'h30;
    localparam logic [7:0]  CH_UPPER_F = 8'h46;

    typedef enum int { LINE_GOING, LINE_DONE, LINE_TOO_LONG } line_st_t;

    typedef enum int {
        SC_BODY, SC_NO_CRLF, SC_LONG_SIZE, SC_LONG_TRAILER, SC_SATURATE, SC_CUT, SC_NOISE
    } scenario_t;

    // One word waiting to be sent, with its idle gap and an optional drain request.
    typedef struct {
        item_t word;
        int    gap;
        bit    drain;
    } pending_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    push = 1'b0;
    logic    full;
    item_t   item = '0;
    logic    empty;
    logic    pop = 1'b0;
    result_t result;

    pending_t pending_q[$];
    result_t  expected_q[$];
    int       backlog = 0;
    int       mismatches = 0;
    int       cycle_cnt = 0;

    // Sender and receiver pacing.
    int hold_cnt = 0;
    bit armed = 1'b0;
    int pop_wait = 0;
    bit recv_burst = 1'b0;

    // Stimulus construction flags.
    bit restart_next = 1'b0;
    bit drain_next = 1'b0;
    bit sender_burst = 1'b0;

    // Decoder state as predicted.
    phase_t      dec_phase;
    logic [63:0] chunk_left;
    logic [6:0]  line_len;
    logic        seen_cr;
    logic        hex_done;
    logic        blanks_done;

    http_chunked_body_decoder #(
        .LINE_BUFFER(LINE_BUFFER_DEF)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(item),
        .empty(empty),
        .pop(pop),
        .result(result)
    );

    // Free-running clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The run is cut off if it takes far longer than any correct run could.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Print a mismatch and count it; only the first 40 are printed.
    task automatic report_mismatch(input string msg);
        if (mismatches < 40)
            $display("chunk check: %s", msg);
        mismatches++;
    endtask

    // Value of a hex digit, or 16 for any other byte.
    function automatic logic [4:0] hex_of(input logic [7:0] ch);
        if (ch >= 8'h30 && ch <= 8'h39)
            return 5'(ch - 8'h30);
        if (ch >= 8'h61 && ch <= 8'h66)
            return 5'(ch - 8'h61) + 5'd10;
        if (ch >= 8'h41 && ch <= 8'h46)
            return 5'(ch - 8'h41) + 5'd10;
        return 5'd16;
    endfunction

    task automatic fresh_line();
        line_len = '0;
        seen_cr = 1'b0;
        hex_done = 1'b0;
        blanks_done = 1'b0;
    endtask

    task automatic clear_decoder();
        dec_phase = PH_SIZE;
        chunk_left = '0;
        fresh_line();
    endtask

    // One character of a CR LF terminated line; parse enables size accumulation.
    task automatic scan_line_char(input logic [7:0] ch, input bit parse, output line_st_t st);
        logic [4:0] h;
        if (seen_cr && ch == CH_LF)
            st = LINE_DONE;
        else
        begin
            seen_cr = (ch == CH_CR);
            if (parse && (blanks_done || (ch != CH_SPACE && ch != CH_TAB)))
            begin
                blanks_done = 1'b1;
                h = hex_of(ch);
                if (!hex_done)
                begin
                    if (h == 5'd16)
                        hex_done = 1'b1;
                    else if (chunk_left > ((MAX64 - 64'(h)) >> 4))
                        chunk_left = MAX64;
                    else
                        chunk_left = {chunk_left[59:0], h[3:0]};
                end
            end
            line_len = line_len + 7'd1;
            st = (line_len >= LINE_LIMIT) ? LINE_TOO_LONG : LINE_GOING;
        end
    endtask

    // Advance the predicted decoder by one accepted word.
    task automatic decode_word(input item_t w, output bit got, output result_t r);
        line_st_t   st;
        logic [6:0] len_prev;
        logic [7:0] ch;
        ch = w.in_byte;
        got = 1'b0;
        r = '0;
        if (w.start_of_body)
            clear_decoder();
        case (dec_phase)
            PH_SIZE:
            begin
                scan_line_char(ch, 1'b1, st);
                if (st == LINE_TOO_LONG)
                begin
                    dec_phase = PH_FAILED;
                    got = 1'b1;
                    r.result_kind = KIND_LONG;
                end
                else if (st == LINE_DONE)
                begin
                    dec_phase = (chunk_left == '0) ? PH_TRAILER : PH_DATA;
                    fresh_line();
                end
            end
            PH_DATA:
            begin
                if (chunk_left != '0)
                    chunk_left = chunk_left - 64'd1;
                if (chunk_left == '0)
                    dec_phase = PH_CR;
                got = 1'b1;
                r.result_kind = KIND_PAYLOAD;
                r.out_byte = ch;
            end
            PH_CR, PH_LF:
            begin
                if (ch != ((dec_phase == PH_CR) ? CH_CR : CH_LF))
                begin
                    dec_phase = PH_FAILED;
                    got = 1'b1;
                    r.result_kind = KIND_NO_CRLF;
                end
                else if (dec_phase == PH_CR)
                    dec_phase = PH_LF;
                else
                begin
                    dec_phase = PH_SIZE;
                    chunk_left = '0;
                    fresh_line();
                end
            end
            PH_TRAILER:
            begin
                len_prev = line_len;
                scan_line_char(ch, 1'b0, st);
                if (st == LINE_TOO_LONG || (st == LINE_DONE && len_prev == 7'd1))
                begin
                    dec_phase = PH_DONE;
                    got = 1'b1;
                    r.result_kind = KIND_COMPLETE;
                end
                else if (st == LINE_DONE)
                    fresh_line();
            end
            default:
            begin
            end
        endcase
    endtask

    // Sender: presents queued words, honoring gaps and drain requests.
    always @(posedge clk)
    begin : driver
        logic push_nx;
        if (!rst_n)
            push <= 1'b0;
        else if (!push || !full)
        begin
            push_nx = 1'b0;
            if (pending_q.size() != 0)
            begin
                if (!armed)
                begin
                    hold_cnt = pending_q[0].gap;
                    armed = 1'b1;
                end
                if (hold_cnt > 0)
                    hold_cnt--;
                else if (!(pending_q[0].drain && (push || backlog != 0)))
                begin
                    item <= pending_q[0].word;
                    push_nx = 1'b1;
                    void'(pending_q.pop_front());
                    armed = 1'b0;
                end
            end
            push <= push_nx;
        end
    end

    // Receiver: pops results with a random stall after each accepted word.
    always @(posedge clk)
    begin : receiver
        int gap;
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_wait <= 0;
        end
        else if (pop && !empty)
        begin
            if ($urandom_range(0, 59) == 0)
                recv_burst = !recv_burst;
            gap = recv_burst ? 0 : int'($urandom_range(0, 11));
            if (gap != 0)
            begin
                pop <= 1'b0;
                pop_wait <= gap;
            end
        end
        else if (!pop)
        begin
            if (pop_wait > 1)
                pop_wait <= pop_wait - 1;
            else
                pop <= 1'b1;
        end
    end

    // Monitor: predicts on every accepted input word and checks every accepted result.
    always @(posedge clk)
    begin : monitor
        bit      got;
        result_t want;
        result_t pred;
        if (!rst_n)
            clear_decoder();
        else
        begin
            if (push && !full)
            begin
                decode_word(item, got, pred);
                if (got)
                    expected_q.push_back(pred);
            end
            if (pop && !empty)
            begin
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("unexpected word kind %0d byte %02h",
                                              result.result_kind, result.out_byte));
                else
                begin
                    want = expected_q.pop_front();
                    if (result.result_kind != want.result_kind)
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  result.result_kind, want.result_kind));
                    if (result.out_byte != want.out_byte)
                        report_mismatch($sformatf("byte %02h, expected %02h",
                                                  result.out_byte, want.out_byte));
                end
            end
        end
        backlog <= expected_q.size();
    end

    // Queue one byte; the first byte of a body carries the restart flag.
    task automatic add_byte(input logic [7:0] b);
        pending_t p;
        p.word.start_of_body = restart_next;
        p.word.in_byte = b;
        p.gap = sender_burst ? 0 : int'($urandom_range(0, 11));
        p.drain = drain_next;
        restart_next = 1'b0;
        drain_next = 1'b0;
        pending_q.push_back(p);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic add_crlf();
        add_byte(CH_CR);
        add_byte(CH_LF);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10)
            return CH_DIGIT0 + 8'(v);
        return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] text_char();
        return 8'($urandom_range(33, 126));
    endfunction

    task automatic add_payload(input int n);
        int i;
        for (i = 0; i < n; i++)
            add_byte(8'($urandom_range(0, 255)));
    endtask

    // Optional leading spaces and tabs.
    task automatic add_blanks();
        int n;
        int i;
        n = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 2)) : 0;
        for (i = 0; i < n; i++)
            add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endtask

    // Optional extension after the digits, sometimes with a bare CR inside.
    task automatic add_extension();
        int n;
        int i;
        if ($urandom_range(0, 3) == 0)
        begin
            if ($urandom_range(0, 2) == 0)
                add_byte(CH_SPACE);
            add_byte(CH_SEMI);
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 5) == 0)
                    add_byte(CH_CR);
                add_byte(text_char());
            end
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            add_byte(CH_CR);
            add_byte(text_char());
        end
    endtask

    // A full size line for the given size, in random case with optional zeros.
    task automatic add_size_line(input logic [63:0] size);
        int nd;
        int k;
        add_blanks();
        nd = 16;
        while (nd > 1 && 4'(size >> (4 * (nd - 1))) == 4'd0)
            nd--;
        if ($urandom_range(0, 3) == 0)
            for (k = 0; k < int'($urandom_range(1, 2)); k++)
                add_byte(CH_DIGIT0);
        for (k = nd - 1; k >= 0; k--)
            add_byte(hex_char(4'(size >> (4 * k)), bit'($urandom_range(0, 1))));
        add_extension();
        add_crlf();
    endtask

    // The terminating size line in one of its zero-size forms.
    task automatic add_last_chunk();
        case ($urandom_range(0, 5))
            0, 1, 2: add_size_line(64'd0);
            3:
            begin
                if ($urandom_range(0, 1))
                begin
                    add_blanks();
                    add_byte(CH_SEMI);
                    add_byte(text_char());
                end
                add_crlf();
            end
            4:
            begin
                add_text("0x10");
                add_crlf();
            end
            default:
            begin
                add_text("-5");
                add_crlf();
            end
        endcase
    endtask

    // Trailer lines, some with a bare CR, then the empty line.
    task automatic add_trailers();
        int lines;
        int n;
        int l;
        int i;
        lines = $urandom_range(0, 2);
        for (l = 0; l < lines; l++)
        begin
            if ($urandom_range(0, 5) == 0)
                add_byte(CH_CR);
            else
            begin
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 7) == 0)
                        add_byte(CH_CR);
                    add_byte(text_char());
                end
            end
            add_crlf();
        end
        add_crlf();
    endtask

    function automatic int chunk_size();
        return ($urandom_range(0, 9) == 0) ? int'($urandom_range(9, 40))
                                           : int'($urandom_range(1, 8));
    endfunction

    task automatic build_scenario(input scenario_t sc);
        int          n;
        int          i;
        logic [7:0]  b;
        case (sc)
            SC_BODY:
            begin
                restart_next = 1'b1;
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                begin
                    b = 8'(chunk_size());
                    add_size_line(64'(b));
                    add_payload(int'(b));
                    add_crlf();
                end
                add_last_chunk();
                add_trailers();
                add_payload($urandom_range(0, 2));
            end
            SC_NO_CRLF:
            begin
                restart_next = 1'b1;
                n = $urandom_range(1, 6);
                add_size_line(64'(n));
                add_payload(n);
                if ($urandom_range(0, 1))
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == CH_CR);
                    add_byte(b);
                end
                else
                begin
                    add_byte(CH_CR);
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == CH_LF);
                    add_byte(b);
                end
                add_payload($urandom_range(0, 3));
            end
            SC_LONG_SIZE:
            begin
                // Lengths straddle the line limit, counting the CR.
                restart_next = 1'b1;
                n = $urandom_range(58, 66);
                add_text("1");
                add_byte(CH_SEMI);
                for (i = 2; i < n; i++)
                    add_byte(8'($urandom_range(32, 126)));
                add_crlf();
                add_payload(1);
                add_crlf();
                add_text("0");
                add_crlf();
                add_crlf();
            end
            SC_LONG_TRAILER:
            begin
                restart_next = 1'b1;
                add_size_line(64'd0);
                n = $urandom_range(58, 66);
                for (i = 0; i < n; i++)
                    add_byte(8'($urandom_range(32, 126)));
                add_crlf();
                add_crlf();
            end
            SC_SATURATE:
            begin
                restart_next = 1'b1;
                n = $urandom_range(16, 20);
                add_byte($urandom_range(0, 1) ? CH_UPPER_F : hex_char(4'($urandom_range(1, 15)), 1'b1));
                for (i = 1; i < n; i++)
                    add_byte(hex_char(4'($urandom_range(0, 15)), bit'($urandom_range(0, 1))));
                add_crlf();
                add_payload($urandom_range(3, 10));
            end
            SC_CUT:
            begin
                // The next body restarts the decoder in the middle of this one.
                restart_next = 1'b1;
                n = $urandom_range(2, 8);
                add_size_line(64'(n));
                add_payload($urandom_range(1, n - 1));
            end
            default:
            begin
                n = $urandom_range(10, 40);
                for (i = 0; i < n; i++)
                begin
                    restart_next = ($urandom_range(0, 7) == 0);
                    if ($urandom_range(0, 2) == 0)
                        case ($urandom_range(0, 6))
                            0: b = CH_CR;
                            1: b = CH_LF;
                            2: b = CH_SPACE;
                            3: b = CH_TAB;
                            4: b = CH_DIGIT0;
                            5: b = CH_UPPER_F;
                            default: b = CH_SEMI;
                        endcase
                    else
                        b = 8'($urandom_range(0, 255));
                    add_byte(b);
                end
            end
        endcase
    endtask

    // Stimulus, reset and the end of the run.
    initial
    begin : stimulus
        int        sc_index;
        int        r;
        scenario_t sc;

        // A minimal body, a byte after completion, a missing CRLF, a byte after
        // failure, and a size line without digits.
        restart_next = 1'b1;
        add_text("1");
        add_crlf();
        add_text("A");
        add_crlf();
        add_text("0");
        add_crlf();
        add_crlf();
        add_byte(8'hFF);
        restart_next = 1'b1;
        add_byte(CH_TAB);
        add_text("2");
        add_crlf();
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text("X");
        add_byte(CH_LF);
        restart_next = 1'b1;
        add_text("g");
        add_crlf();
        add_crlf();

        // Random part: every scenario once, then a weighted mix.
        sc_index = 0;
        while (pending_q.size() < RANDOM_TARGET)
        begin
            if (sc_index < 7)
                sc = scenario_t'(sc_index);
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    sc = SC_BODY;
                else if (r < 65)
                    sc = SC_NO_CRLF;
                else if (r < 72)
                    sc = SC_LONG_SIZE;
                else if (r < 78)
                    sc = SC_LONG_TRAILER;
                else if (r < 84)
                    sc = SC_SATURATE;
                else if (r < 92)
                    sc = SC_CUT;
                else
                    sc = SC_NOISE;
            end
            sender_burst = ($urandom_range(0, 4) == 0);
            drain_next = (sc_index == 0) || ($urandom_range(0, 14) == 0);
            build_scenario(sc);
            sc_index++;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every word to be sent and every result to come back.
        while (pending_q.size() != 0 || push)
            @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d expected words never arrived", expected_q.size()));
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
